// ===== src/activation_bank_fill_read_defines.svh =====
// ----------------------------------------------------------------------------
// Activation bank assertion macros
// Shared checks, written against the clk / rst_n of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ACTIVATION_BANK_FILL_READ_DEFINES_SVH
`define ACTIVATION_BANK_FILL_READ_DEFINES_SVH

// same-cycle implication, masked while in reset
`define ABFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abfr: same-cycle check failed");

// next-cycle implication, masked while in reset
`define ABFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abfr: next-cycle check failed");

`endif

// ===== src/abfr_pkg.sv =====
// ----------------------------------------------------------------------------
// abfr_pkg
// Types, codes and helpers for the activation bank fill/read block.
// ----------------------------------------------------------------------------
`default_nettype none

package abfr_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int WORD_W        = 64;
    localparam int LANES         = 8;
    localparam logic [7:0] LANE_ON = 8'hFF;

    typedef enum logic [2:0] {
        OP_RESET      = 3'd0,
        OP_FILL       = 3'd1,
        OP_WRITE      = 3'd2,
        OP_BEGIN_READ = 3'd3,
        OP_READ       = 3'd4,
        OP_COMPLETE   = 3'd5
    } abfr_op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_STATE = 3'd1,
        ST_DESC  = 3'd2,
        ST_MASK  = 3'd3,
        ST_LAST  = 3'd4,
        ST_INDEX = 3'd5
    } abfr_status_t;

    typedef enum logic [1:0] {
        PH_EMPTY   = 2'd0,
        PH_WRITING = 2'd1,
        PH_READY   = 2'd2,
        PH_READING = 2'd3
    } abfr_phase_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_LOAD = 1'b1
    } abfr_ctrl_state_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [10:0]        n_words;
        logic [7:0]         byte_en;
        logic signed [15:0] tid;
        logic [63:0]        write_data;
        logic               last_flag;
        logic [9:0]         read_index;
    } abfr_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [1:0]         bank_state;
        logic [9:0]         out_index;
        logic               out_last;
        logic [7:0]         out_byte_en;
        logic signed [15:0] out_tag;
        logic [63:0]        read_data;
    } abfr_result_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // transaction taken this cycle
        logic load;     // move pending result into the output register
    } abfr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy; // output register full and stalled
        logic out_full; // output register holds a result
    } abfr_sts_t;

    // byte-lane keep mask: lane i kept when mask bit i is set
    function automatic logic [WORD_W-1:0] lane_keep(input logic [LANES-1:0] mask);
        logic [WORD_W-1:0] keep;
        keep = '0;
        for (int i = 0; i < LANES; i++) begin
            if (mask[i])
            begin
                keep[i*8 +: 8] = LANE_ON;
            end
        end
        return keep;
    endfunction

endpackage

`default_nettype wire

// ===== src/abfr_ram.sv =====
// ----------------------------------------------------------------------------
// abfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module abfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/abfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// abfr_ctrl
// Two-state sequencer: take a transaction, then hand its result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module abfr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire abfr_pkg::abfr_sts_t sts,
    output abfr_pkg::abfr_cmd_t      cmd
);

    import abfr_pkg::*;

    abfr_ctrl_state_t state_reg;
    abfr_ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = CS_LOAD;
                end
            end
            CS_LOAD:
            begin
                if (!sts.out_busy)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall = 1'b1;
        cmd        = '0;
        case (state_reg)
            CS_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
            end
            CS_LOAD:
            begin
                cmd.load = !sts.out_busy;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/abfr_dp.sv =====
// ----------------------------------------------------------------------------
// abfr_dp
// Bank state registers, opcode decode, word store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module abfr_dp #(
    parameter int DEPTH = abfr_pkg::DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire abfr_pkg::abfr_item_t  item,
    input  wire abfr_pkg::abfr_cmd_t   cmd,
    output abfr_pkg::abfr_sts_t        sts,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output abfr_pkg::abfr_result_t     result
);

    import abfr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [16:0] DEPTH_V = 17'(DEPTH);

    // bank state
    abfr_phase_t        phase_reg,    phase_next;
    logic [10:0]        expected_reg, expected_next;
    logic [10:0]        stored_reg,   stored_next;
    logic [7:0]         mask_reg,     mask_next;
    logic signed [15:0] tag_reg,      tag_next;

    // result pending the RAM read
    abfr_result_t       pend_reg,     pend_next;
    logic               hit_reg,      hit_next;

    abfr_result_t       out_reg,      out_next;
    logic               out_valid_reg, out_valid_next;

    logic               mem_we;
    logic               mem_re;
    logic [WORD_W-1:0]  mem_rdata;
    logic [10:0]        stored_inc;
    logic               final_word;

    assign stored_inc = stored_reg + 11'd1;
    assign final_word = (stored_inc == expected_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        stored_next   = stored_reg;
        mask_next     = mask_reg;
        tag_next      = tag_reg;
        pend_next     = '0;
        hit_next      = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        pend_next.status = ST_OK;

        case (item.opcode)
            OP_RESET, OP_COMPLETE:
            begin
                if (item.opcode == OP_COMPLETE && phase_reg != PH_READING)
                begin
                    pend_next.status = ST_STATE;
                end
                else
                begin
                    phase_next    = PH_EMPTY;
                    expected_next = '0;
                    stored_next   = '0;
                    mask_next     = '0;
                    tag_next      = '0;
                end
            end
            OP_FILL:
            begin
                if (phase_reg != PH_EMPTY)
                begin
                    pend_next.status = ST_STATE;
                end
                else if (item.n_words == '0 || {6'd0, item.n_words} > DEPTH_V ||
                         item.byte_en == '0 || item.tid[15])
                begin
                    pend_next.status = ST_DESC;
                end
                else
                begin
                    expected_next = item.n_words;
                    mask_next     = item.byte_en;
                    tag_next      = item.tid;
                    stored_next   = '0;
                    phase_next    = PH_WRITING;
                end
            end
            OP_WRITE:
            begin
                if (phase_reg != PH_WRITING)
                begin
                    pend_next.status = ST_STATE;
                end
                else if (item.byte_en != mask_reg || stored_reg >= expected_reg)
                begin
                    pend_next.status = ST_MASK;
                end
                else
                begin
                    // word is stored even on a last-flag mismatch
                    mem_we      = 1'b1;
                    stored_next = stored_inc;
                    if (item.last_flag != final_word)
                    begin
                        pend_next.status = ST_LAST;
                    end
                    else if (final_word)
                    begin
                        phase_next = PH_READY;
                    end
                end
            end
            OP_BEGIN_READ:
            begin
                if (phase_reg != PH_READY)
                begin
                    pend_next.status = ST_STATE;
                end
                else
                begin
                    phase_next = PH_READING;
                end
            end
            OP_READ:
            begin
                if (phase_reg != PH_READING)
                begin
                    pend_next.status = ST_STATE;
                end
                else if ({1'b0, item.read_index} >= expected_reg)
                begin
                    pend_next.status = ST_INDEX;
                end
                else
                begin
                    mem_re                  = 1'b1;
                    hit_next                = 1'b1;
                    pend_next.out_index     = item.read_index;
                    pend_next.out_last      = (({1'b0, item.read_index} + 11'd1) == expected_reg);
                    pend_next.out_byte_en   = mask_reg;
                    pend_next.out_tag       = tag_reg;
                end
            end
            default:
            begin
                pend_next.status = ST_STATE;
            end
        endcase
        pend_next.bank_state = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_EMPTY;
            expected_reg <= '0;
            stored_reg   <= '0;
            mask_reg     <= '0;
            tag_reg      <= '0;
        end
        else if (cmd.accept)
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            stored_reg   <= stored_next;
            mask_reg     <= mask_next;
            tag_reg      <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pend_reg <= pend_next;
            hit_reg  <= hit_next;
        end
    end

    abfr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.accept && mem_we),
        .waddr (AW'(stored_reg)),
        .wdata (item.write_data & lane_keep(mask_reg)),
        .re    (cmd.accept && mem_re),
        .raddr (AW'(item.read_index)),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // pending fields plus the word from the store on a good read
    always_comb
    begin
        out_next           = pend_reg;
        out_next.read_data = hit_reg ? mem_rdata : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_reg <= out_next;
        end
    end

    assign sts.out_busy = out_valid_reg && result_stall;
    assign sts.out_full = out_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ===== src/activation_bank_fill_read.sv =====
// An accepted item is registered into the pending fields and the RAM read data, then loaded
// into the output register, which drives the result transaction.
// The sequencer takes no new item until that result is loaded (accept, then load of the RAM read).
// A stalled full output register lets one more item in, which then waits and stalls the input.
// Reset (rst_n low, asynchronous): bank empty, counters, mask and tag zero, no result pending.
// The word store has no reset; only entries written in the current fill are ever read.
// ----------------------------------------------------------------------------
// activation_bank_fill_read
// Activation buffer bank with empty / writing / ready / reading ownership,
// driven by one opcode item per transaction, one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "activation_bank_fill_read_defines.svh"

module activation_bank_fill_read #(
    parameter int DEPTH = abfr_pkg::DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // item channel
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire abfr_pkg::abfr_item_t  item,
    // result channel
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output abfr_pkg::abfr_result_t     result
);

    import abfr_pkg::*;

    abfr_cmd_t cmd;
    abfr_sts_t sts;

    // Controller: IDLE takes a transaction, LOAD waits for the RAM read and
    // for room in the output register.
    abfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Datapath: decode and bank state update happen on accept; the RAM read
    // data joins the pending fields when the result is loaded.
    abfr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // no back-to-back accepts: the sequencer is busy for the cycle after
    `ABFR_ASSERT_NEXT(a_no_b2b_accept, item_valid && !item_stall, item_stall)
    // a load never overwrites a result still held by the receiver
    `ABFR_ASSERT_NOW(a_load_free, cmd.load, !(sts.out_full && result_stall))
    // a loaded result shows up on the port
    `ABFR_ASSERT_NEXT(a_load_valid, cmd.load, result_valid)
    // the last mark only comes with a good read
    `ABFR_ASSERT_NOW(a_last_ok, result_valid && result.out_last, result.status == ST_OK)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: activation_bank_fill_read testbench
// Drives opcode transactions through the bank and predicts every result from
// a local model of the ownership phases, counters and word store. Covers each
// error status, a full-depth tensor, long output hold-off and random traffic
// under three idle schedules.
// ----------------------------------------------------------------------------

module tb;
    import abfr_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 12;       // margin after the last expected result
    localparam int CYCLE_LIMIT  = 400000;

    // opcodes the block does not define
    localparam logic [2:0] OP_UNDEF_6 = 3'd6;
    localparam logic [2:0] OP_UNDEF_7 = 3'd7;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         item_valid   = 1'b0;
    logic         item_stall;
    abfr_item_t   item         = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    abfr_result_t result;

    // idle percentages, set by the test sequence
    int send_idle_pct = 0;
    int rcv_idle_pct  = 0;

    int errors      = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    // results predicted for accepted transactions, oldest first
    abfr_result_t expected_results[$];

    // local copy of the bank
    abfr_phase_t  cur_phase  = PH_EMPTY;
    logic [10:0]  words_due  = '0;
    logic [10:0]  words_held = '0;
    logic [7:0]   lane_sel   = '0;
    logic [15:0]  tag_held   = '0;
    logic [63:0]  mem_words [DEPTH];

    // receiver hold-off, owned by its own process
    event hold_go;
    logic holding = 1'b0;

    activation_bank_fill_read #(
        .DEPTH(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[activation_bank_fill_read] ERROR");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // Bank model
    // --------------------------------------------------------------------
    function automatic void clear_model();
        cur_phase  = PH_EMPTY;
        words_due  = '0;
        words_held = '0;
        lane_sel   = '0;
        tag_held   = '0;
    endfunction

    // Result of one item; updates the local bank copy.
    // Violations leave the bank alone, except a last-flag mismatch, which
    // still stores and counts the word but never moves the bank to ready.
    function automatic abfr_result_t bank_predict(input abfr_item_t it);
        abfr_result_t r;
        logic [63:0]  kept;
        logic         is_final;
        r = '0;
        r.status = ST_OK;
        case (it.opcode)
            OP_RESET:
                clear_model();
            OP_FILL:
                if (cur_phase != PH_EMPTY)
                    r.status = ST_STATE;
                else if (it.n_words == '0 || 32'(it.n_words) > DEPTH ||
                         it.byte_en == '0 || it.tid[15])
                    r.status = ST_DESC;
                else
                begin
                    words_due  = it.n_words;
                    lane_sel   = it.byte_en;
                    tag_held   = it.tid;
                    words_held = '0;
                    cur_phase  = PH_WRITING;
                end
            OP_WRITE:
                if (cur_phase != PH_WRITING)
                    r.status = ST_STATE;
                else if (it.byte_en != lane_sel || words_held >= words_due)
                    r.status = ST_MASK;
                else
                begin
                    // lanes outside the held mask are stored as zero
                    kept = '0;
                    for (int ln = 0; ln < LANES; ln++)
                    begin
                        if (lane_sel[ln])
                            kept[ln*8 +: 8] = it.write_data[ln*8 +: 8];
                    end
                    mem_words[10'(words_held)] = kept;
                    words_held = words_held + 11'd1;
                    is_final   = (words_held == words_due);
                    if (it.last_flag != is_final)
                        r.status = ST_LAST;
                    else if (is_final)
                        cur_phase = PH_READY;
                end
            OP_BEGIN_READ:
                if (cur_phase != PH_READY)
                    r.status = ST_STATE;
                else
                    cur_phase = PH_READING;
            OP_READ:
                if (cur_phase != PH_READING)
                    r.status = ST_STATE;
                else if ({1'b0, it.read_index} >= words_due)
                    r.status = ST_INDEX;
                else
                begin
                    r.out_index   = it.read_index;
                    r.out_last    = (({1'b0, it.read_index} + 11'd1) == words_due);
                    r.out_byte_en = lane_sel;
                    r.out_tag     = tag_held;
                    r.read_data   = mem_words[it.read_index];
                end
            OP_COMPLETE:
                if (cur_phase != PH_READING)
                    r.status = ST_STATE;
                else
                    clear_model();
            default:
                r.status = ST_STATE;
        endcase
        r.bank_state = cur_phase;
        return r;
    endfunction

    // --------------------------------------------------------------------
    // Item side
    // --------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after the
    // transaction is taken. Valid stays up into the next call, which lowers
    // it only if it decides to idle.
    task automatic send_item(input abfr_item_t it);
        abfr_result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        want = bank_predict(it);
        expected_results = {expected_results, want};
        items_sent++;
        @(negedge clk);
    endtask

    // fully random item, unused fields carry junk
    function automatic abfr_item_t junk_item();
        abfr_item_t it;
        it.opcode     = 3'($urandom_range(7));
        it.n_words    = 11'($urandom_range(2047));
        it.byte_en    = 8'($urandom_range(255));
        it.tid        = 16'($urandom_range(65535));
        it.write_data = {$urandom, $urandom};
        it.last_flag  = 1'($urandom_range(1));
        it.read_index = 10'($urandom_range(1023));
        return it;
    endfunction

    task automatic send_plain(input logic [2:0] op);
        abfr_item_t it;
        it = junk_item();
        it.opcode = op;
        send_item(it);
    endtask

    task automatic send_fill(input logic [10:0] count, input logic [7:0] mask,
                             input logic signed [15:0] tag);
        abfr_item_t it;
        it = junk_item();
        it.opcode     = OP_FILL;
        it.n_words    = count;
        it.byte_en    = mask;
        it.tid        = tag;
        send_item(it);
    endtask

    task automatic send_write(input logic [7:0] mask, input logic [63:0] data,
                              input logic last);
        abfr_item_t it;
        it = junk_item();
        it.opcode     = OP_WRITE;
        it.byte_en    = mask;
        it.write_data = data;
        it.last_flag  = last;
        send_item(it);
    endtask

    task automatic send_read(input logic [9:0] idx);
        abfr_item_t it;
        it = junk_item();
        it.opcode     = OP_READ;
        it.read_index = idx;
        send_item(it);
    endtask

    // occasional stray transaction that breaks a tensor sequence
    task automatic stray_item(input bit noisy);
        if (noisy && $urandom_range(24) == 0)
            send_item(junk_item());
    endtask

    // One tensor: fill, n writes, begin read, reads (first and last word
    // always), then complete or a reset opcode. With noisy set, strays and
    // wrong last flags are mixed in.
    task automatic run_tensor(input int n, input bit noisy);
        logic [7:0]  mask;
        logic [15:0] tag;
        logic        last;
        int          reads;
        mask = 8'($urandom_range(1, 255));
        tag  = 16'($urandom_range(32767));
        send_fill(11'(n), mask, tag);
        for (int i = 0; i < n; i++)
        begin
            stray_item(noisy);
            last = (i == n - 1);
            if (noisy && $urandom_range(15) == 0)
                last = !last;
            send_write(mask, {$urandom, $urandom}, last);
        end
        stray_item(noisy);
        send_plain(OP_BEGIN_READ);
        send_read(10'd0);
        send_read(10'(n - 1));
        reads = $urandom_range(0, 6);
        repeat (reads)
        begin
            stray_item(noisy);
            if ($urandom_range(9) == 0)
                send_read(10'($urandom_range(1023)));
            else
                send_read(10'($urandom_range(n - 1)));
        end
        stray_item(noisy);
        if ($urandom_range(9) == 0)
            send_plain(OP_RESET);
        else
            send_plain(OP_COMPLETE);
    endtask

    // --------------------------------------------------------------------
    // Result side
    // --------------------------------------------------------------------
    // stall is redrawn every falling edge; a hold-off forces it high
    always @(negedge clk)
        result_stall <= holding || ($urandom_range(99) < rcv_idle_pct);

    initial
    begin
        forever
        begin
            @(hold_go);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding = 1'b0;
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        abfr_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $error("result transaction with nothing expected");
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 64'(want.status), 64'(result.status));
                check_field("bank_state", 64'(want.bank_state), 64'(result.bank_state));
                check_field("out_index", 64'(want.out_index), 64'(result.out_index));
                check_field("out_last", 64'(want.out_last), 64'(result.out_last));
                check_field("out_byte_en", 64'(want.out_byte_en),
                            64'(result.out_byte_en));
                check_field("out_tag", 64'(unsigned'(want.out_tag)),
                            64'(unsigned'(result.out_tag)));
                check_field("read_data", want.read_data, result.read_data);
            end
        end
    end

    // --------------------------------------------------------------------
    // Tests
    // --------------------------------------------------------------------
    // reset opcode, undefined opcodes and bank moves from empty
    task automatic test_reset_and_bad_opcodes();
        send_plain(OP_RESET);
        send_plain(OP_UNDEF_6);
        send_plain(OP_UNDEF_7);
        send_plain(OP_WRITE);
        send_plain(OP_BEGIN_READ);
        send_plain(OP_READ);
        send_plain(OP_COMPLETE);
    endtask

    // each bad descriptor, then a good one at the top tag value
    task automatic test_descriptor_checks();
        send_fill(11'd0, 8'hff, 16'sd1);
        send_fill(11'(DEPTH + 1), 8'hff, 16'sd1);
        send_fill(11'h7ff, 8'h01, 16'sd1);
        send_fill(11'd4, 8'h00, 16'sd1);
        send_fill(11'd4, 8'hff, -16'sd1);
        send_fill(11'd4, 8'hff, 16'sh8000);
        send_fill(11'd2, 8'h81, 16'sh7fff);
        send_fill(11'd2, 8'h81, 16'sh7fff);     // not empty any more
    endtask

    // bank holds a 2-word tensor with mask 0x81
    task automatic test_write_checks();
        send_write(8'h80, '1, 1'b0);            // mask mismatch
        send_plain(OP_BEGIN_READ);              // still writing
        send_write(8'h81, '1, 1'b1);            // early last, word kept
        send_write(8'h81, '0, 1'b0);            // missing last on final word
        send_write(8'h81, '1, 1'b1);            // overflow
        send_plain(OP_RESET);
    endtask

    task automatic test_read_flow();
        send_fill(11'd1, 8'hff, 16'sd0);
        send_write(8'hff, '1, 1'b1);
        send_write(8'hff, '0, 1'b1);            // bank is ready, not writing
        send_read(10'd0);                       // read before begin read
        send_plain(OP_BEGIN_READ);
        send_plain(OP_BEGIN_READ);
        send_fill(11'd1, 8'hff, 16'sd0);
        send_read(10'd0);
        send_read(10'd1);                       // past the word count
        send_read(10'h3ff);
        send_plain(OP_COMPLETE);
        send_plain(OP_COMPLETE);
    endtask

    // mostly small well-formed tensors, some noise and broken sequences
    task automatic test_random_traffic(input int n);
        int start;
        int size;
        start = items_sent;
        while (items_sent - start < n)
        begin
            if ($urandom_range(9) < 8)
            begin
                // a stuck bank is usually cleared first
                if (cur_phase != PH_EMPTY && $urandom_range(3) != 0)
                    send_plain(OP_RESET);
                size = ($urandom_range(19) == 0) ? $urandom_range(9, 64)
                                                 : $urandom_range(1, 8);
                run_tensor(size, $urandom_range(4) == 0);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_item(junk_item());
            end
        end
    endtask

    // every entry of the store written and the top index read back
    task automatic test_full_depth_tensor();
        if (cur_phase != PH_EMPTY)
            send_plain(OP_RESET);
        run_tensor(DEPTH, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering, so the output
    // register fills and the block stalls its input
    task automatic test_output_hold_off();
        if (cur_phase != PH_EMPTY)
            send_plain(OP_RESET);
        -> hold_go;
        run_tensor(24, 1'b0);
    endtask

    // --------------------------------------------------------------------
    // Sequence
    // --------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 9;
        rcv_idle_pct  = 74;
        test_reset_and_bad_opcodes();
        test_descriptor_checks();
        test_write_checks();
        test_read_flow();
        test_random_traffic(250);

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 74;
        rcv_idle_pct  = 9;
        test_random_traffic(250);

        // back to back
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        test_random_traffic(250);
        test_full_depth_tensor();
        test_output_hold_off();

        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[activation_bank_fill_read] OK");
        else
            $display("[activation_bank_fill_read] ERROR");
        $finish;
    end

endmodule
